// ===== sv/gpg_pkg.sv =====
`timescale 1ns / 1ps

package gpg_pkg;

	// fixed point and size limits
	localparam int FRAC_BITS  = 16;
	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = 13;
	localparam int POS_W      = 12;
	localparam int COORD_W    = 14;
	localparam int SQ_W       = 26;
	localparam int FEED_W     = 32;
	localparam int DIV_STEPS  = 32;
	localparam int SQRT_STEPS = 16;
	localparam int ROOT_W     = 16;
	localparam int SREM_W     = 18;
	localparam int DQ_W       = 26;
	localparam int COEF_W     = 27;
	localparam int PROD_W     = 36;
	localparam int LANES      = 4;
	localparam int LANE_MAIN  = 0;
	localparam int CHANNELS   = 3;

	// diagonal distance clamp: large enough that any color difference saturates
	localparam logic [DQ_W-1:0] DQ_SAT = DQ_W'(1) << 25;

	typedef enum logic [2:0] {
		MODE_HORIZ     = 3'd0,
		MODE_VERT      = 3'd1,
		MODE_RADIAL    = 3'd2,
		MODE_FWD_DIAG  = 3'd3,
		MODE_BACK_DIAG = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_START  = 3'd0,
		REG_END    = 3'd1,
		REG_MODE   = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	// live configuration seen by the front and blend stages
	typedef struct packed {
		logic [23:0]       start_colour;
		logic [23:0]       end_colour;
		logic [2:0]        gradient_mode;
		logic [DIM_W-1:0]  wd;
		logic [DIM_W-1:0]  ht;
		logic [SQ_W-1:0]   sq;
	} cfg_t;

	typedef struct packed {
		logic beyond;
		logic above;
		logic ovf;
	} side_t;

	// one restoring divider lane
	typedef struct packed {
		logic [SQ_W-1:0]   rem;
		logic [FEED_W-1:0] feed;
		logic [FEED_W-1:0] quo;
		logic [SQ_W-1:0]   dvs;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		side_t             side;
	} div_t;

	typedef struct packed {
		logic [SREM_W-1:0]         rem;
		logic [ROOT_W-1:0]         root;
		logic [FEED_W-1:0]         feed;
		logic [DQ_W-1:0]           dq;
		logic [CHANNELS-1:0][7:0]  hv;
		side_t                     side;
	} sqr_t;

	// zero acts as one, oversize acts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

// ===== sv/gpg_div_cell.sv =====
`timescale 1ns / 1ps

module gpg_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  gpg_pkg::div_t d_i,
	output logic          vld_o,
	output gpg_pkg::div_t d_o
);
	import gpg_pkg::*;

	div_t nxt;

	// one quotient bit per lane
	always_comb begin
		nxt = d_i;
		for (int k = 0; k < LANES; k++) begin
			logic [SQ_W:0] t;
			logic          ge;
			t  = {d_i.lane[k].rem, d_i.lane[k].feed[FEED_W-1]};
			ge = (t >= {1'b0, d_i.lane[k].dvs});
			nxt.lane[k].rem  = ge ? SQ_W'(t - {1'b0, d_i.lane[k].dvs}) : t[SQ_W-1:0];
			nxt.lane[k].feed = {d_i.lane[k].feed[FEED_W-2:0], 1'b0};
			nxt.lane[k].quo  = {d_i.lane[k].quo[FEED_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en)
			d_o <= nxt;
	end

endmodule

// ===== sv/gpg_sqrt_cell.sv =====
`timescale 1ns / 1ps

module gpg_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  gpg_pkg::sqr_t d_i,
	output logic          vld_o,
	output gpg_pkg::sqr_t d_o
);
	import gpg_pkg::*;

	sqr_t              nxt;
	logic [SREM_W+1:0] t;
	logic [SREM_W+1:0] trial;
	logic              ge;

	// one root bit from two radicand bits
	always_comb begin
		nxt   = d_i;
		t     = {d_i.rem, d_i.feed[FEED_W-1 -: 2]};
		trial = {2'b00, d_i.root, 2'b01};
		ge    = (t >= trial);
		nxt.rem  = ge ? SREM_W'(t - trial) : t[SREM_W-1:0];
		nxt.root = {d_i.root[ROOT_W-2:0], ge};
		nxt.feed = {d_i.feed[FEED_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en)
			d_o <= nxt;
	end

endmodule

// ===== sv/gpg_front.sv =====
`timescale 1ns / 1ps

module gpg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [23:0]   in_data,
	input  gpg_pkg::cfg_t cfg,
	output logic          vld_o,
	output gpg_pkg::div_t d_o
);
	import gpg_pkg::*;

	logic [POS_W-1:0] row, col;
	logic             vert;
	logic             v_s1, v_s2, v_s3;

	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic [POS_W-1:0]          p_s1;

	logic signed [27:0] xx_full, yy_full, yw_full, xh_full;
	logic [24:0]        xx_s2, yy_s2;
	logic signed [27:0] yw_s2, xh_s2;
	logic signed [21:0] pd_s2 [CHANNELS];
	logic [20:0]        sb_s2 [CHANNELS];

	logic [27:0]        r4_s3;
	logic signed [27:0] a_s3;
	logic signed [22:0] num_s3 [CHANNELS];

	logic [26:0]       mag;
	logic              beyond, ovf;
	logic [DIM_W-1:0]  size;
	div_t              nxt;

	assign row  = in_data[POS_W-1:0];
	assign col  = in_data[2*POS_W-1:POS_W];
	assign vert = (cfg.gradient_mode == MODE_VERT);
	assign size = vert ? cfg.ht : cfg.wd;

	// stage 1: centered coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= $signed({2'b00, col}) - $signed({2'b00, cfg.wd[DIM_W-1:1]});
			y_s1 <= $signed({2'b00, row}) - $signed({2'b00, cfg.ht[DIM_W-1:1]});
			p_s1 <= vert ? row : col;
		end
	end

	// stage 2: products
	assign xx_full = x_s1 * x_s1;
	assign yy_full = y_s1 * y_s1;
	assign yw_full = y_s1 * $signed({1'b0, cfg.wd});
	assign xh_full = x_s1 * $signed({1'b0, cfg.ht});

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2 <= xx_full[24:0];
			yy_s2 <= yy_full[24:0];
			yw_s2 <= yw_full;
			xh_s2 <= xh_full;
			for (int c = 0; c < CHANNELS; c++) begin
				pd_s2[c] <= $signed({1'b0, p_s1}) *
					($signed({1'b0, cfg.end_colour[(2-c)*8 +: 8]}) -
					 $signed({1'b0, cfg.start_colour[(2-c)*8 +: 8]}));
				sb_s2[c] <= cfg.start_colour[(2-c)*8 +: 8] * size;
			end
		end
	end

	// stage 3: sums
	always_ff @(posedge clk) begin
		if (en) begin
			r4_s3 <= {({1'b0, xx_s2} + {1'b0, yy_s2}), 2'b00};
			a_s3  <= (cfg.gradient_mode == MODE_FWD_DIAG) ? (yw_s2 - xh_s2) : (yw_s2 + xh_s2);
			for (int c = 0; c < CHANNELS; c++)
				num_s3[c] <= $signed({2'b00, sb_s2[c]}) + $signed({pd_s2[c][21], pd_s2[c]});
		end
	end

	// stage 4: divider lane setup
	assign mag    = a_s3[27] ? 27'(-a_s3) : a_s3[26:0];
	assign beyond = (r4_s3 > {2'b00, cfg.sq});
	assign ovf    = ({8'b0, mag} >= {cfg.sq, 9'b0});

	always_comb begin
		nxt = '0;
		nxt.side.beyond = beyond;
		nxt.side.above  = !a_s3[27] && (a_s3 != '0);
		nxt.side.ovf    = ovf;
		nxt.lane[LANE_MAIN].dvs = cfg.sq;
		if (cfg.gradient_mode == MODE_RADIAL) begin
			nxt.lane[LANE_MAIN].rem = beyond ? '0 : r4_s3[SQ_W-1:0];
		end else if (!ovf) begin
			nxt.lane[LANE_MAIN].rem  = SQ_W'(mag[26:FRAC_BITS]);
			nxt.lane[LANE_MAIN].feed = {mag[FRAC_BITS-1:0], {(FEED_W-FRAC_BITS){1'b0}}};
		end
		for (int c = 0; c < CHANNELS; c++) begin
			nxt.lane[c+1].dvs = SQ_W'(size);
			if (!num_s3[c][22] && (num_s3[c] != '0))
				nxt.lane[c+1].feed = FEED_W'(num_s3[c][21:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_o <= nxt;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			v_s1  <= in_vld;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			vld_o <= v_s3;
		end
	end

endmodule

// ===== sv/gpg_blend.sv =====
`timescale 1ns / 1ps

module gpg_blend (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_i,
	input  gpg_pkg::sqr_t                   d_i,
	input  gpg_pkg::cfg_t                   cfg,
	output logic                            vld_o,
	output logic [gpg_pkg::CHANNELS-1:0][7:0] px_o
);
	import gpg_pkg::*;

	localparam logic signed [COEF_W-1:0] ONE_C  = COEF_W'(1) << FRAC_BITS;
	localparam logic signed [COEF_W-1:0] HALF_C = COEF_W'(1) << (FRAC_BITS - 1);

	logic                       v_b1, v_b2;
	logic signed [COEF_W-1:0]   ce_b1, cs_b1;
	logic [CHANNELS-1:0][7:0]   hv_b1, hv_b2;
	logic                       beyond_b1, beyond_b2;
	logic signed [PROD_W-1:0]   pe_b2 [CHANNELS];
	logic signed [PROD_W-1:0]   ps_b2 [CHANNELS];

	logic signed [COEF_W-1:0]   dqs, rts, ce, cs;
	logic signed [PROD_W:0]     sum [CHANNELS];
	logic [CHANNELS-1:0][7:0]   px;

	// coefficients for end and start color
	assign dqs = $signed({1'b0, d_i.dq});
	assign rts = $signed(COEF_W'(d_i.root));

	always_comb begin
		ce = '0;
		cs = '0;
		if (cfg.gradient_mode == MODE_RADIAL) begin
			ce = rts;
			cs = ONE_C - rts;
		end else if (d_i.side.above) begin
			ce = HALF_C - dqs;
			cs = HALF_C + dqs;
		end else begin
			ce = HALF_C + dqs;
			cs = HALF_C - dqs;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ce_b1     <= ce;
			cs_b1     <= cs;
			hv_b1     <= d_i.hv;
			beyond_b1 <= d_i.side.beyond;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			hv_b2     <= hv_b1;
			beyond_b2 <= beyond_b1;
			for (int c = 0; c < CHANNELS; c++) begin
				pe_b2[c] <= ce_b1 * $signed({1'b0, cfg.end_colour[(2-c)*8 +: 8]});
				ps_b2[c] <= cs_b1 * $signed({1'b0, cfg.start_colour[(2-c)*8 +: 8]});
			end
		end
	end

	// sum, saturate, pick by mode
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			sum[c] = $signed({pe_b2[c][PROD_W-1], pe_b2[c]}) +
				$signed({ps_b2[c][PROD_W-1], ps_b2[c]});
			px[c] = '0;
			unique case (cfg.gradient_mode)
				MODE_HORIZ, MODE_VERT: px[c] = hv_b2[c];
				MODE_RADIAL, MODE_FWD_DIAG, MODE_BACK_DIAG: begin
					if (cfg.gradient_mode == MODE_RADIAL && beyond_b2)
						px[c] = cfg.end_colour[(2-c)*8 +: 8];
					else if (sum[c][PROD_W])
						px[c] = 8'h00;
					else if (|sum[c][PROD_W-1:FRAC_BITS+8])
						px[c] = 8'hFF;
					else
						px[c] = sum[c][FRAC_BITS+7:FRAC_BITS];
				end
				default: px[c] = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			px_o <= px;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1  <= 1'b0;
			v_b2  <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			v_b1  <= vld_i;
			v_b2  <= v_b1;
			vld_o <= v_b2;
		end
	end

endmodule

// ===== sv/gradient_pixel_generator.sv =====
`timescale 1ns / 1ps

// Gradient pixel generator: one pixel position in, one blue/green/red pixel out.
// Slave channel s_*: one beat per pixel position. Master channel m_*: one beat
// per pixel, in the order the positions were taken.
// Configuration: cfg_we/cfg_index/cfg_data write start color, end color, mode,
// width and height; write only while no pixel is in flight.
// An accepted position reaches m_tvalid as its pixel after passing through
// 4 setup stages (coordinates, products, sums, divider setup), 32 divider cells,
// 16 square root cells and 3 blend stages (coefficients, products, output).
// Throughput: one pixel per clock unless stalled; each cell takes a new beat
// each cycle the chain advances. All stages advance together when the output
// register is empty or taken, so s_tready follows m_tready while m_tvalid is
// high; a stalled receiver holds the whole chain, the pending pixel on m_tdata.
// Reset clears all valid bits and loads the register defaults (black to white,
// horizontal, 640 by 480); the derived squared diagonal, registered after the
// squares of the clamped sizes, settles before the first pixel needs it.
module gradient_pixel_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_row[11:0], pixel_column[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // blue_byte[7:0], green_byte[15:8], red_byte[23:16]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import gpg_pkg::*;

	logic [23:0]      start_q, end_q;
	logic [2:0]       mode_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [SQ_W-1:0]  ww_q, hh_q, sq_q;
	cfg_t             cfg;
	logic             adv;

	div_t div_d [DIV_STEPS+1];
	logic div_v [DIV_STEPS+1];
	sqr_t sqr_d [SQRT_STEPS+1];
	logic sqr_v [SQRT_STEPS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 24'h000000;
			end_q    <= 24'hFFFFFF;
			mode_q   <= MODE_HORIZ;
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:  start_q  <= cfg_data;
				REG_END:    end_q    <= cfg_data;
				REG_MODE:   mode_q   <= cfg_data[2:0];
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// derived size terms
	always_ff @(posedge clk) begin
		ww_q <= SQ_W'(cfg.wd) * SQ_W'(cfg.wd);
		hh_q <= SQ_W'(cfg.ht) * SQ_W'(cfg.ht);
		sq_q <= ww_q + hh_q;
	end

	assign cfg.start_colour  = start_q;
	assign cfg.end_colour    = end_q;
	assign cfg.gradient_mode = mode_q;
	assign cfg.wd            = clamp_dim(width_q);
	assign cfg.ht            = clamp_dim(height_q);
	assign cfg.sq            = sq_q;

	// global advance
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	gpg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (s_tvalid),
		.in_data (s_tdata),
		.cfg     (cfg),
		.vld_o   (div_v[0]),
		.d_o     (div_d[0])
	);

	// divider chain
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		gpg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (div_v[g]),
			.d_i    (div_d[g]),
			.vld_o  (div_v[g+1]),
			.d_o    (div_d[g+1])
		);
	end

	// quotients into root chain input
	always_comb begin
		sqr_d[0]      = '0;
		sqr_d[0].feed = div_d[DIV_STEPS].lane[LANE_MAIN].quo;
		sqr_d[0].dq   = div_d[DIV_STEPS].side.ovf ? DQ_SAT :
			div_d[DIV_STEPS].lane[LANE_MAIN].quo[DQ_W-1:0];
		sqr_d[0].side = div_d[DIV_STEPS].side;
		for (int c = 0; c < CHANNELS; c++)
			sqr_d[0].hv[c] = (|div_d[DIV_STEPS].lane[c+1].quo[FEED_W-1:8]) ? 8'hFF :
				div_d[DIV_STEPS].lane[c+1].quo[7:0];
	end
	assign sqr_v[0] = div_v[DIV_STEPS];

	// square root chain
	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		gpg_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (sqr_v[g]),
			.d_i    (sqr_d[g]),
			.vld_o  (sqr_v[g+1]),
			.d_o    (sqr_d[g+1])
		);
	end

	gpg_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (sqr_v[SQRT_STEPS]),
		.d_i    (sqr_d[SQRT_STEPS]),
		.cfg    (cfg),
		.vld_o  (m_tvalid),
		.px_o   (m_tdata)
	);

endmodule
